// ===== rtl/fixed_point_exponential_core_assert.svh =====
// ---------------------------------------------------------------------------
// fixed_point_exponential_core_assert
// assertion macros for the exponential core rtl, used by fpe_stage
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_EXPONENTIAL_CORE_ASSERT_SVH
`define FIXED_POINT_EXPONENTIAL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked out of reset only
`define FPE_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("fpe assertion failed");

// checked at every edge, reset included
`define FPE_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("fpe assertion failed");

`else

`define FPE_ASSERT(name, clk, rst_n, prop)
`define FPE_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== rtl/fpe_pkg.sv =====
// ---------------------------------------------------------------------------
// fpe_pkg
// types, constants and tables of the shift-add exponential pipeline
// ---------------------------------------------------------------------------
package fpe_pkg;

	localparam int ARG_W     = 16;
	localparam int RES_W     = 18;
	localparam int OPND_W    = 14;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int ROM_DEPTH = 16;

	localparam logic [RES_W-1:0] ONE_Q16    = RES_W'(65536);
	localparam logic [RES_W-1:0] RESULT_MAX = RES_W'(262143);

	typedef struct packed {
		logic [ARG_W-1:0] rem;
		logic [RES_W-1:0] acc;
	} fpe_data_t;

	// ln(1 + 2^-i) * 65536, truncated
	function automatic logic [ARG_W-1:0] ln_rom(input logic [3:0] idx);
		logic [ARG_W-1:0] val;
		case (idx)
			4'd0:    val = 16'd45426;
			4'd1:    val = 16'd26572;
			4'd2:    val = 16'd14623;
			4'd3:    val = 16'd7719;
			4'd4:    val = 16'd3973;
			4'd5:    val = 16'd2016;
			4'd6:    val = 16'd1016;
			4'd7:    val = 16'd510;
			4'd8:    val = 16'd255;
			4'd9:    val = 16'd127;
			4'd10:   val = 16'd63;
			4'd11:   val = 16'd31;
			4'd12:   val = 16'd15;
			4'd13:   val = 16'd7;
			4'd14:   val = 16'd3;
			default: val = 16'd1;
		endcase
		return val;
	endfunction

	// (1 + 2^-i) in q16, pre-shifted right by 4
	function automatic logic [OPND_W-1:0] step_factor(input logic [3:0] idx);
		logic [RES_W-1:0] full;
		full = ONE_Q16 + (ONE_Q16 >> idx);
		return full[OPND_W+3:4];
	endfunction

endpackage

// ===== rtl/fpe_stage.sv =====
// ---------------------------------------------------------------------------
// fpe_stage
// one normalization step: trial subtract, truncating multiply, select
// ---------------------------------------------------------------------------
`include "fixed_point_exponential_core_assert.svh"

module fpe_stage #(
	parameter int STAGE_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  fpe_pkg::fpe_data_t in_data,
	output logic              out_vld,
	output fpe_pkg::fpe_data_t out_data
);
	import fpe_pkg::*;

	localparam logic [3:0]        IDX    = 4'(STAGE_IDX);
	localparam logic [ARG_W-1:0]  LN_VAL = ln_rom(IDX);
	localparam logic [OPND_W-1:0] FACTOR = step_factor(IDX);

	logic [PROD_W-1:0]       prod_full;
	logic [PROD_W-9:0]       prod;
	logic [RES_W-1:0]        prod_sat;
	logic                    take;
	logic                    vld_s;
	fpe_data_t               data_s;

	assign prod_full = in_data.acc[RES_W-1:4] * FACTOR;
	assign prod      = prod_full[PROD_W-1:8];
	assign prod_sat  = (prod > {2'b00, RESULT_MAX}) ? RESULT_MAX : prod[RES_W-1:0];
	assign take      = (in_data.rem >= LN_VAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else begin
			vld_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s.rem <= in_data.rem - LN_VAL;
			data_s.acc <= prod_sat;
		end else begin
			data_s <= in_data;
		end
	end

	assign out_vld  = vld_s;
	assign out_data = data_s;

	`FPE_ASSERT_ALWAYS(a_vld_clear_in_reset, clk, !arst_n |=> !vld_s)
	`FPE_ASSERT(a_vld_follows, clk, arst_n, vld_s == $past(in_vld))
	`FPE_ASSERT(a_rem_no_grow, clk, arst_n, in_vld |=> data_s.rem <= $past(in_data.rem))
	`FPE_ASSERT(a_skip_keeps_acc, clk, arst_n,
		(in_vld && in_data.rem < LN_VAL) |=> data_s.acc == $past(in_data.acc))

endmodule

// ===== rtl/fixed_point_exponential_core.sv =====
// start reaches done through one register per step (ITERATIONS, capped at 16) and one output register
// throughput: one request per cycle, busy is never raised
// each step is one 14 x 14 multiply and a 16-bit compare in its own pipeline stage
// the result strobe done lasts one cycle and cannot be stalled by the receiver
// reset: arst_n clears all valid bits and done at once; payload registers are not reset
// ---------------------------------------------------------------------------
// fixed_point_exponential_core
// e^x for x in unsigned q0.16, result in q2.16, by pipelined shift-add normalization
// ---------------------------------------------------------------------------
module fixed_point_exponential_core #(
	parameter int ITERATIONS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] argument,
	output logic        done,
	output logic [17:0] exp_value
);
	import fpe_pkg::*;

	localparam int STEPS = (ITERATIONS > ROM_DEPTH) ? ROM_DEPTH : ITERATIONS;

	logic      vld [0:STEPS];
	fpe_data_t pipe [0:STEPS];
	logic      done_q;
	logic [RES_W-1:0] exp_value_q;

	assign busy     = 1'b0;
	assign vld[0]   = start;
	assign pipe[0]  = '{rem: argument, acc: ONE_Q16};

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		fpe_stage #(
			.STAGE_IDX(g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[g]),
			.in_data  (pipe[g]),
			.out_vld  (vld[g+1]),
			.out_data (pipe[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		exp_value_q <= pipe[STEPS].acc;
	end

	assign done      = done_q;
	assign exp_value = exp_value_q;

endmodule

// ===== bench/fixed_point_exponential_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_point_exponential_core_tb
// self-checking bench for the pipelined shift-add exponential core: corner
// arguments, back-to-back requests and random arguments with random idle
// gaps are sent, every result is compared with a bit-exact prediction
// ---------------------------------------------------------------------------
module fixed_point_exponential_core_tb;

	localparam int ITERATIONS = 10;
	localparam int STEPS      = (ITERATIONS > 16) ? 16 : ITERATIONS;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 1900;

	// ln(1 + 2^-i) in q16, entry i at bits [16*i +: 16]
	localparam logic [255:0] LN_TABLE = {
		16'd1,    16'd3,    16'd7,    16'd15,   16'd31,   16'd63,   16'd127,  16'd255,
		16'd510,  16'd1016, 16'd2016, 16'd3973, 16'd7719, 16'd14623, 16'd26572, 16'd45426
	};
	localparam logic [17:0] EXP_MAX = 18'd262143;

	typedef struct {
		logic [15:0] arg;
		logic [17:0] value;
	} exp_expect_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] argument;
	logic        done;
	logic [17:0] exp_value;

	exp_expect_t pending_exp[$];
	int          mismatches = 0;
	int          idle_cycles = 0;

	fixed_point_exponential_core #(
		.ITERATIONS(ITERATIONS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.argument (argument),
		.done     (done),
		.exp_value(exp_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] ln_step(input int idx);
		return LN_TABLE[idx*16 +: 16];
	endfunction

	function automatic logic [17:0] predict_exp(input logic [15:0] arg);
		logic [31:0] rem_q;
		logic [31:0] acc_q;
		logic [31:0] factor;
		logic [63:0] prod;
		rem_q = {16'd0, arg};
		acc_q = 32'd65536;
		for (int i = 0; i < STEPS; i++) begin
			factor = 32'd65536 + (32'd65536 >> i);
			prod   = (64'(acc_q >> 4) * 64'(factor >> 4)) >> 8;
			if (rem_q >= {16'd0, ln_step(i)}) begin
				rem_q = rem_q - {16'd0, ln_step(i)};
				acc_q = prod[31:0];
			end
		end
		if (acc_q > {14'd0, EXP_MAX})
			acc_q = {14'd0, EXP_MAX};
		return acc_q[17:0];
	endfunction

	function automatic int idle_gap(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_argument();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($urandom_range(0, 65535));
		if (r < 80) begin
			// around a step threshold
			v = int'(ln_step($urandom_range(0, STEPS - 1))) + $urandom_range(0, 4) - 2;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			return 16'(v);
		end
		if (r < 90)
			return 16'($urandom_range(65000, 65535));
		return 16'($urandom_range(0, 1023));
	endfunction

	task automatic send_request(input logic [15:0] arg, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		argument <= arg;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_exp.push_back('{arg: arg, value: predict_exp(arg)});
	endtask

	task automatic test_corner_arguments();
		logic [15:0] corner_args[$];
		corner_args = '{16'd0, 16'd1, 16'd65535, 16'd65534, 16'h8000, 16'h7fff,
			16'h5555, 16'haaaa, 16'd45425, 16'd26571, 16'd60049};
		for (int i = 0; i < STEPS; i++)
			corner_args.push_back(ln_step(i));
		foreach (corner_args[i])
			send_request(corner_args[i], idle_gap(1'b0));
	endtask

	task automatic test_back_to_back();
		for (int i = 0; i < 64; i++)
			send_request(pick_argument(), 0);
	endtask

	task automatic test_random_arguments();
		int sent;
		int seg_len;
		bit burst;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			seg_len = $urandom_range(20, 80);
			burst   = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < seg_len && sent < RANDOM_REQUESTS; i++) begin
				send_request(pick_argument(), idle_gap(burst));
				sent++;
			end
		end
	endtask

	// result check
	always @(posedge clk) begin
		exp_expect_t head;
		if (arst_n && done) begin
			if (pending_exp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result exp_value=%0d", exp_value);
			end else begin
				head = pending_exp.pop_front();
				if (exp_value !== head.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("argument=%0d expected exp_value=%0d actual=%0d",
							head.arg, head.value, exp_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("fixed_point_exponential_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		argument = 16'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_arguments();
		test_back_to_back();
		test_random_arguments();

		start <= 1'b0;
		while (pending_exp.size() != 0)
			@(posedge clk);
		repeat (ITERATIONS + 4) @(posedge clk);

		if (mismatches == 0)
			$display("fixed_point_exponential_core: match");
		else
			$display("fixed_point_exponential_core: mismatch");
		$finish;
	end

endmodule
